// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge outside reset
`define SDTSN_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define SDTSN_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== hw/rtl/sdtsn_pkg.sv =====
// ----------------------------------------------------------------------------
// sdtsn_pkg
// Types and constants for the SDT service name parser.
// ----------------------------------------------------------------------------
package sdtsn_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] KIND_IDS      = 2'd0;
    localparam logic [1:0] KIND_PROVIDER = 2'd1;
    localparam logic [1:0] KIND_SERVICE  = 2'd2;

    localparam logic [7:0] TAG_SERVICE   = 8'h48;
    localparam logic [7:0] SEL_LIMIT     = 8'h20;
    localparam logic [7:0] SEL_TRIPLE    = 8'h10;
    localparam logic [7:0] UTF8_LEAD     = 8'hC0;
    localparam logic [7:0] UTF8_CONT     = 8'h80;

    localparam logic [1:0] SEL_FIRST     = 2'd3;
    localparam logic [1:0] SEL_TWO_MORE  = 2'd2;
    localparam logic [1:0] SEL_COPY      = 2'd0;

    localparam logic [11:0] POS_MAX      = 12'hFFF;
    localparam logic [11:0] POS_LEN_HI   = 12'd1;
    localparam logic [11:0] POS_LEN_LO   = 12'd2;
    localparam logic [11:0] POS_TSID_HI  = 12'd3;
    localparam logic [11:0] POS_TSID_LO  = 12'd4;
    localparam logic [11:0] POS_NID_HI   = 12'd8;
    localparam logic [11:0] POS_NID_LO   = 12'd9;
    localparam logic [11:0] POS_HDR_END  = 12'd10;

    typedef enum logic [14:0] {
        PH_IDLE   = 15'b000000000000001,
        PH_HDR    = 15'b000000000000010,
        PH_SID_HI = 15'b000000000000100,
        PH_SID_LO = 15'b000000000001000,
        PH_FLAGS  = 15'b000000000010000,
        PH_DL_HI  = 15'b000000000100000,
        PH_DL_LO  = 15'b000000001000000,
        PH_TAG    = 15'b000000010000000,
        PH_DLEN   = 15'b000000100000000,
        PH_STYPE  = 15'b000001000000000,
        PH_PLEN   = 15'b000010000000000,
        PH_PNAME  = 15'b000100000000000,
        PH_SLEN   = 15'b001000000000000,
        PH_SNAME  = 15'b010000000000000,
        PH_SKIP   = 15'b100000000000000
    } phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] service_id;
        logic [15:0] transport_stream_id;
        logic [15:0] network_id;
        logic [7:0]  data;
        logic        last;
    } entry_t;

endpackage

// ===== hw/rtl/sdt_section_service_name_parser.sv =====
// ----------------------------------------------------------------------------
// sdt_section_service_name_parser
// SDT section parser that streams stream ids and provider and service names as UTF-8.
// ----------------------------------------------------------------------------
// Input channel s_*: one section byte per request, s_section_start on the
// table_id byte. Output channel m_*: one request per result; kind 0 carries
// the transport stream id and network id once per section, kinds 1 and 2
// carry provider and service name bytes, m_last on the final byte of a name.
// A byte is parsed in the cycle it is accepted; its result is written into
// the queue and shows on m_* once earlier entries have been taken. The
// parser takes one byte per cycle while the queue is not full; a Latin-1 name
// byte of 0x80 and above gives two results, a UTF-8 lead and continuation byte.
// A two-entry queue between parser and output stage sets how far the parser
// runs ahead: when it is full, s_ready drops until the receiver takes the
// final result of the oldest entry. While m_ready is low the current result
// holds on m_*.
// Synchronous reset clears the queue and returns the parser to idle, where
// bytes are dropped until a section start arrives.
// ----------------------------------------------------------------------------
module sdt_section_service_name_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_section_start,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [15:0] m_service_id,
    output logic [15:0] m_transport_stream_id,
    output logic [15:0] m_network_id,
    output logic [7:0]  m_name_byte,
    output logic        m_last
);
    import sdtsn_pkg::*;

    logic   push;
    entry_t push_entry;
    logic   pop;
    logic   full;
    logic   empty;
    entry_t head;

    sdtsn_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_section_start (s_section_start),
        .queue_full      (full),
        .push            (push),
        .push_entry      (push_entry)
    );

    sdtsn_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (full),
        .empty      (empty),
        .head       (head)
    );

    sdtsn_back u_back (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .empty                 (empty),
        .head                  (head),
        .pop                   (pop),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_kind                (m_kind),
        .m_service_id          (m_service_id),
        .m_transport_stream_id (m_transport_stream_id),
        .m_network_id          (m_network_id),
        .m_name_byte           (m_name_byte),
        .m_last                (m_last)
    );

endmodule

// ===== hw/rtl/sdtsn_front.sv =====
// ----------------------------------------------------------------------------
// sdtsn_front
// Section byte parser: walks header, service entries and descriptors and
// pushes one request per id emission or kept name byte.
// ----------------------------------------------------------------------------
module sdtsn_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_data_byte,
    input  logic               s_section_start,
    input  logic               queue_full,
    output logic               push,
    output sdtsn_pkg::entry_t  push_entry
);
    import sdtsn_pkg::*;

    logic [11:0] pos_reg, pos_next;
    logic [11:0] sec_len_reg, sec_len_next;
    logic [15:0] tsid_reg, tsid_next;
    logic [15:0] nid_reg, nid_next;
    logic [15:0] sid_reg, sid_next;
    phase_t      phase_reg, phase_next;
    logic [11:0] loop_reg, loop_next;
    logic [7:0]  desc_reg, desc_next;
    logic [7:0]  tag_reg, tag_next;
    logic [7:0]  name_reg, name_next;
    logic [1:0]  sel_reg, sel_next;

    logic        accept;
    logic [11:0] pos_n;
    logic [11:0] lr;
    logic [11:0] avail;
    logic [11:0] loop_len;
    logic [11:0] loop_min;
    logic [7:0]  dr;
    logic [7:0]  dl_min;
    logic [7:0]  nm;
    logic [7:0]  name_dec;
    logic        name_emit;
    logic [1:0]  sel_after;
    phase_t      ph;

    assign s_ready = !queue_full;
    assign accept  = s_valid && s_ready;

    assign name_dec = (name_reg != 8'd0) ? name_reg - 8'd1 : 8'd0;

    always_comb begin
        name_emit = 1'b0;
        sel_after = SEL_COPY;
        if (sel_reg == SEL_FIRST) begin
            if (s_data_byte < SEL_LIMIT) begin
                sel_after = (s_data_byte == SEL_TRIPLE) ? SEL_TWO_MORE : SEL_COPY;
            end else begin
                name_emit = 1'b1;
            end
        end else if (sel_reg != SEL_COPY) begin
            sel_after = sel_reg - 2'd1;
        end else begin
            name_emit = 1'b1;
        end
    end

    always_comb begin
        pos_next     = pos_reg;
        sec_len_next = sec_len_reg;
        tsid_next    = tsid_reg;
        nid_next     = nid_reg;
        sid_next     = sid_reg;
        phase_next   = phase_reg;
        loop_next    = loop_reg;
        desc_next    = desc_reg;
        tag_next     = tag_reg;
        name_next    = name_reg;
        sel_next     = sel_reg;
        push         = 1'b0;
        push_entry.kind                = KIND_IDS;
        push_entry.service_id          = sid_reg;
        push_entry.transport_stream_id = tsid_reg;
        push_entry.network_id          = nid_reg;
        push_entry.data                = s_data_byte;
        push_entry.last                = 1'b0;
        pos_n    = (pos_reg != POS_MAX) ? pos_reg + 12'd1 : pos_reg;
        lr       = (loop_reg != 12'd0) ? loop_reg - 12'd1 : 12'd0;
        avail    = sec_len_reg - 12'd2 - pos_n;
        loop_len = {loop_reg[11:8], s_data_byte};
        loop_min = (loop_len < avail) ? loop_len : avail;
        dl_min   = (lr < {4'd0, s_data_byte}) ? lr[7:0] : s_data_byte;
        dr       = (desc_reg != 8'd0) ? desc_reg - 8'd1 : 8'd0;
        nm       = (s_data_byte < dr) ? s_data_byte : dr;
        ph       = phase_reg;

        if (accept) begin
            if (s_section_start) begin
                pos_next     = 12'd0;
                sec_len_next = 12'd0;
                phase_next   = PH_HDR;
                loop_next    = 12'd0;
                desc_next    = 8'd0;
                tag_next     = 8'd0;
                name_next    = 8'd0;
                sel_next     = SEL_COPY;
            end else if (phase_reg != PH_IDLE) begin
                pos_next = pos_n;
                if (phase_reg == PH_HDR) begin
                    case (pos_n)
                        POS_LEN_HI:  sec_len_next = {s_data_byte[3:0], 8'h00};
                        POS_LEN_LO:  sec_len_next = {sec_len_reg[11:8], s_data_byte};
                        POS_TSID_HI: tsid_next = {s_data_byte, tsid_reg[7:0]};
                        POS_TSID_LO: tsid_next = {tsid_reg[15:8], s_data_byte};
                        POS_NID_HI:  nid_next = {s_data_byte, nid_reg[7:0]};
                        POS_NID_LO: begin
                            nid_next = {nid_reg[15:8], s_data_byte};
                            push     = 1'b1;
                            push_entry.service_id = 16'd0;
                            push_entry.network_id = {nid_reg[15:8], s_data_byte};
                            push_entry.data       = 8'd0;
                        end
                        POS_HDR_END: phase_next = PH_SID_HI;
                        default: ;
                    endcase
                end else if ({1'b0, pos_n} + 13'd1 >= {1'b0, sec_len_reg}) begin
                    phase_next = PH_IDLE;
                end else begin
                    case (phase_reg)
                        PH_SID_HI: begin
                            sid_next   = {s_data_byte, sid_reg[7:0]};
                            phase_next = PH_SID_LO;
                        end
                        PH_SID_LO: begin
                            sid_next   = {sid_reg[15:8], s_data_byte};
                            phase_next = PH_FLAGS;
                        end
                        PH_FLAGS: phase_next = PH_DL_HI;
                        PH_DL_HI: begin
                            loop_next  = {s_data_byte[3:0], 8'h00};
                            phase_next = PH_DL_LO;
                        end
                        PH_DL_LO: begin
                            loop_next  = loop_min;
                            phase_next = (loop_min == 12'd0) ? PH_SID_HI : PH_TAG;
                        end
                        default: begin
                            loop_next = lr;
                            if (phase_reg == PH_TAG) begin
                                tag_next = s_data_byte;
                                ph       = PH_DLEN;
                            end else if (phase_reg == PH_DLEN) begin
                                desc_next = dl_min;
                                if (dl_min == 8'd0) begin
                                    ph = PH_TAG;
                                end else begin
                                    ph = (tag_reg == TAG_SERVICE) ? PH_STYPE : PH_SKIP;
                                end
                            end else begin
                                desc_next = dr;
                                case (phase_reg)
                                    PH_STYPE: ph = PH_PLEN;
                                    PH_PLEN: begin
                                        name_next = nm;
                                        sel_next  = SEL_FIRST;
                                        ph = (nm != 8'd0) ? PH_PNAME : PH_SLEN;
                                    end
                                    PH_SLEN: begin
                                        name_next = nm;
                                        sel_next  = SEL_FIRST;
                                        ph = (nm != 8'd0) ? PH_SNAME : PH_SKIP;
                                    end
                                    PH_PNAME, PH_SNAME: begin
                                        name_next       = name_dec;
                                        sel_next        = sel_after;
                                        push            = name_emit;
                                        push_entry.kind = (phase_reg == PH_PNAME) ?
                                                          KIND_PROVIDER : KIND_SERVICE;
                                        push_entry.last = (name_reg == 8'd1);
                                        if (name_dec == 8'd0) begin
                                            ph = (phase_reg == PH_PNAME) ? PH_SLEN : PH_SKIP;
                                        end
                                    end
                                    default: ;
                                endcase
                                if (dr == 8'd0) begin
                                    ph = PH_TAG;
                                end
                            end
                            if (lr == 12'd0) begin
                                ph = PH_SID_HI;
                            end
                            phase_next = ph;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= 12'd0;
            sec_len_reg <= 12'd0;
            tsid_reg    <= 16'd0;
            nid_reg     <= 16'd0;
            sid_reg     <= 16'd0;
            phase_reg   <= PH_IDLE;
            loop_reg    <= 12'd0;
            desc_reg    <= 8'd0;
            tag_reg     <= 8'd0;
            name_reg    <= 8'd0;
            sel_reg     <= SEL_COPY;
        end else begin
            pos_reg     <= pos_next;
            sec_len_reg <= sec_len_next;
            tsid_reg    <= tsid_next;
            nid_reg     <= nid_next;
            sid_reg     <= sid_next;
            phase_reg   <= phase_next;
            loop_reg    <= loop_next;
            desc_reg    <= desc_next;
            tag_reg     <= tag_next;
            name_reg    <= name_next;
            sel_reg     <= sel_next;
        end
    end

endmodule

// ===== hw/rtl/sdtsn_queue.sv =====
// ----------------------------------------------------------------------------
// sdtsn_queue
// Short request queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module sdtsn_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  sdtsn_pkg::entry_t  push_entry,
    input  logic               pop,
    output logic               full,
    output logic               empty,
    output sdtsn_pkg::entry_t  head
);
    import sdtsn_pkg::*;

    entry_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hw/rtl/sdtsn_back.sv =====
// ----------------------------------------------------------------------------
// sdtsn_back
// Output stage: presents queued requests, splitting Latin-1 bytes of 0x80
// and above into a two-byte UTF-8 sequence.
// ----------------------------------------------------------------------------
module sdtsn_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               empty,
    input  sdtsn_pkg::entry_t  head,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_kind,
    output logic [15:0]        m_service_id,
    output logic [15:0]        m_transport_stream_id,
    output logic [15:0]        m_network_id,
    output logic [7:0]         m_name_byte,
    output logic               m_last
);
    import sdtsn_pkg::*;

    logic half_reg, half_next;
    logic two;
    logic fire;

    assign two     = head.data[7];
    assign m_valid = !empty;
    assign fire    = m_valid && m_ready;
    assign pop     = fire && (!two || half_reg);

    assign m_kind                = head.kind;
    assign m_service_id          = head.service_id;
    assign m_transport_stream_id = head.transport_stream_id;
    assign m_network_id          = head.network_id;
    assign m_last                = head.last && (!two || half_reg);

    always_comb begin
        if (!two) begin
            m_name_byte = head.data;
        end else if (half_reg) begin
            m_name_byte = UTF8_CONT | {2'b00, head.data[5:0]};
        end else begin
            m_name_byte = UTF8_LEAD | {6'd0, head.data[7:6]};
        end
    end

    always_comb begin
        half_next = half_reg;
        if (fire && two) begin
            half_next = !half_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_reg <= 1'b0;
        end else begin
            half_reg <= half_next;
        end
    end

endmodule

// ===== hw/rtl/sdtsn_checker.sv =====
// ----------------------------------------------------------------------------
// sdtsn_checker
// Port-level checks on the result channel of the SDT service name parser.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sdtsn_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_kind,
    input logic [7:0] m_name_byte,
    input logic       m_last
);
    import sdtsn_pkg::*;

    logic is_ids;
    logic is_lead;

    assign is_ids  = m_valid && (m_kind == KIND_IDS);
    assign is_lead = m_valid && (m_name_byte[7:6] == UTF8_LEAD[7:6]);

    `SDTSN_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> !m_valid, "result valid after reset")
    `SDTSN_ASSERT(a_valid_holds, m_valid && !m_ready |=> m_valid, "result dropped while stalled")
    `SDTSN_ASSERT(a_byte_holds, m_valid && !m_ready |=> $stable(m_name_byte), "name byte changed")
    `SDTSN_ASSERT(a_ids_clean, is_ids |-> m_name_byte == 8'd0 && !m_last, "ids with name data")
    `SDTSN_ASSERT(a_lead_not_last, is_lead |-> !m_last, "utf-8 lead byte flagged last")

endmodule

bind sdt_section_service_name_parser sdtsn_checker u_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_kind      (m_kind),
    .m_name_byte (m_name_byte),
    .m_last      (m_last)
);
